/* sv/pfba_pkg.sv */
`timescale 1ns / 1ps
// pfba_pkg: shared types and constants for the page frame bitmap allocator.
// Used by pfba_ctrl, pfba_datapath and page_frame_bitmap_allocator_top.

package pfba_pkg;

    // request modes, carried on the slave tuser
    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_TEST  = 2'd2,
        MODE_MARK  = 2'd3
    } t_mode;

    // result status, carried on the master tuser
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_NOFREE = 2'd1,
        STAT_BEYOND = 2'd2
    } t_status;

    // how the datapath closes out a request
    typedef enum logic [1:0] {
        FIN_ALLOC_OK = 2'd0,
        FIN_FULL     = 2'd1,
        FIN_ACCESS   = 2'd2
    } t_fin_kind;

    localparam int          FC_W          = 13;
    localparam logic [12:0] FC_RESET      = 13'd4096;
    localparam int          APB_AW        = 3;
    localparam int          APB_DW        = 32;
    localparam int          REG_FRAME_CNT = 0;
    localparam int          WORD_BITS     = 32;

    // controller -> datapath
    typedef struct packed {
        logic      clr_step;
        logic      load;
        logic      rd_req;
        logic      scan_start;
        logic      scan_step;
        logic      finish;
        t_fin_kind fin_kind;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic count_zero;
        logic is_alloc;
        logic word_free;
        logic scan_last;
    } t_stat;

endpackage

/* sv/pfba_ctrl.sv */
`timescale 1ns / 1ps
// pfba_ctrl: sequencing FSM for clear pass, scan and result handoff.
// Depends on pfba_pkg; drives pfba_datapath through t_cmd.

module pfba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic           i_m_tready,
    output logic           o_m_tvalid,
    input  pfba_pkg::t_stat i_stat,
    output pfba_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_PREP  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_WAIT  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    pfba_pkg::t_fin_kind r_kind, n_kind;
    logic                r_out_valid, n_out_valid;
    logic                w_slot_free;

    assign w_slot_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_s_tready  = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.fin_kind = r_kind;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                if (i_stat.is_alloc) begin
                    if (i_stat.count_zero) begin
                        n_kind  = pfba_pkg::FIN_FULL;
                        n_state = ST_WAIT;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end else begin
                    o_cmd.rd_req = 1'b1;
                    n_kind       = pfba_pkg::FIN_ACCESS;
                    n_state      = ST_WAIT;
                end
            end
            ST_SCAN: begin
                if (i_stat.word_free || i_stat.scan_last) begin
                    n_kind = i_stat.word_free ? pfba_pkg::FIN_ALLOC_OK : pfba_pkg::FIN_FULL;
                    o_cmd.fin_kind = n_kind;
                    if (w_slot_free) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        n_state = ST_WAIT;   // read data holds while parked
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_WAIT: begin
                if (w_slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish)    n_out_valid = 1'b1;
        else if (i_m_tready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_kind      <= pfba_pkg::FIN_ACCESS;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* sv/pfba_datapath.sv */
`timescale 1ns / 1ps
// pfba_datapath: bitmap memory, request registers, scan counters, result registers.
// Depends on pfba_pkg; commanded by pfba_ctrl.

module pfba_datapath #(
    parameter int MAX_FRAMES = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pfba_pkg::t_cmd            i_cmd,
    output pfba_pkg::t_stat           o_stat,
    input  logic [pfba_pkg::FC_W-1:0] i_frame_count,
    input  logic [1:0]                i_mode,
    input  logic [31:0]               i_frame_address,
    output logic [31:0]               o_result_address,
    output logic                      o_frame_in_use,
    output logic [1:0]                o_status
);

    localparam int WORDS  = (MAX_FRAMES + pfba_pkg::WORD_BITS - 1) / pfba_pkg::WORD_BITS;
    localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PSHIFT = $clog2(PAGE_BYTES);        // page size is a power of two
    localparam int MCW    = $clog2(MAX_FRAMES + 1);
    localparam int CW     = (MCW > pfba_pkg::FC_W) ? MCW : pfba_pkg::FC_W;
    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

    logic [31:0] r_mem [WORDS];
    logic [31:0] r_rd_data;

    pfba_pkg::t_mode r_mode;
    logic [31:0]     r_addr;
    logic [WAW-1:0]  r_ridx, r_cidx, r_clr_idx;
    logic [31:0]     r_res_address;
    logic            r_res_in_use;
    logic [1:0]      r_res_status;

    logic [CW-1:0]   w_cnt, w_last_idx;
    logic [4:0]      w_rem;
    logic [31:0]     w_mask, w_eff, w_inv, w_onehot;
    logic [4:0]      w_bit;
    logic            w_scan_last;
    logic [31:0]     w_frame, w_req_bit;
    logic [WAW-1:0]  w_req_word;
    logic            w_beyond;

    logic            w_rd_en, w_wr_en;
    logic [WAW-1:0]  w_rd_addr, w_wr_addr;
    logic [31:0]     w_wr_data;
    logic [31:0]     n_res_address;
    logic            n_res_in_use;
    logic [1:0]      n_res_status;

    // effective count: frame_count saturated at MAX_FRAMES
    assign w_cnt = (CW'(i_frame_count) > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES)
                                                          : CW'(i_frame_count);
    assign w_last_idx  = (w_cnt - CW'(1)) >> 5;
    assign w_rem       = w_cnt[4:0];
    assign w_scan_last = (CW'(r_cidx) == w_last_idx);

    // frames at or past the count in the last word read as used
    assign w_mask   = (w_scan_last && (w_rem != 5'd0)) ? ~((32'd1 << w_rem) - 32'd1) : 32'd0;
    assign w_eff    = r_rd_data | w_mask;
    assign w_inv    = ~w_eff;
    assign w_onehot = w_inv & (~w_inv + 32'd1);

    always_comb begin
        w_bit = 5'd0;
        for (int b = 0; b < 32; b++) begin
            if (w_onehot[b]) w_bit = w_bit | 5'(b);
        end
    end

    // request frame index
    assign w_frame    = r_addr >> PSHIFT;
    assign w_beyond   = (w_frame >= 32'(w_cnt));
    assign w_req_word = w_frame[WAW+4:5];
    assign w_req_bit  = 32'd1 << w_frame[4:0];

    assign o_stat.clr_last   = (r_clr_idx == LAST_WORD);
    assign o_stat.count_zero = (w_cnt == '0);
    assign o_stat.is_alloc   = (r_mode == pfba_pkg::MODE_ALLOC);
    assign o_stat.word_free  = (w_eff != 32'hFFFF_FFFF);
    assign o_stat.scan_last  = w_scan_last;

    always_comb begin
        w_rd_en       = 1'b0;
        w_rd_addr     = r_ridx;
        w_wr_en       = 1'b0;
        w_wr_addr     = r_cidx;
        w_wr_data     = r_rd_data;
        n_res_address = 32'd0;
        n_res_in_use  = 1'b0;
        n_res_status  = pfba_pkg::STAT_OK;

        if (i_cmd.clr_step) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_idx;
            w_wr_data = (r_clr_idx == '0) ? 32'd1 : 32'd0;   // frame 0 stays reserved
        end
        if (i_cmd.rd_req) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_req_word;
        end
        if (i_cmd.scan_start) begin
            w_rd_en   = 1'b1;
            w_rd_addr = '0;
        end
        if (i_cmd.scan_step) w_rd_en = 1'b1;

        if (i_cmd.finish) begin
            unique case (i_cmd.fin_kind)
                pfba_pkg::FIN_ALLOC_OK: begin
                    w_wr_en       = 1'b1;
                    w_wr_addr     = r_cidx;
                    w_wr_data     = r_rd_data | w_onehot;
                    n_res_address = 32'({r_cidx, w_bit}) << PSHIFT;
                end
                pfba_pkg::FIN_FULL: begin
                    n_res_status = pfba_pkg::STAT_NOFREE;
                end
                pfba_pkg::FIN_ACCESS: begin
                    w_wr_addr = w_req_word;
                    if (r_mode == pfba_pkg::MODE_FREE && r_addr == 32'd0) begin
                        n_res_status = pfba_pkg::STAT_OK;   // null address ignored
                    end else if (w_beyond) begin
                        n_res_status = pfba_pkg::STAT_BEYOND;
                    end else begin
                        unique case (r_mode)
                            pfba_pkg::MODE_FREE: begin
                                w_wr_en   = 1'b1;
                                w_wr_data = r_rd_data & ~w_req_bit;
                            end
                            pfba_pkg::MODE_TEST: n_res_in_use = |(r_rd_data & w_req_bit);
                            pfba_pkg::MODE_MARK: begin
                                w_wr_en   = 1'b1;
                                w_wr_data = r_rd_data | w_req_bit;
                            end
                            pfba_pkg::MODE_ALLOC: ;
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // bitmap store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        if (w_rd_en) r_rd_data <= r_mem[w_rd_addr];
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_ridx    <= '0;
            r_cidx    <= '0;
        end else begin
            if (i_cmd.clr_step && r_clr_idx != LAST_WORD) r_clr_idx <= r_clr_idx + WAW'(1);
            if (i_cmd.scan_start) begin
                r_ridx <= (LAST_WORD == '0) ? '0 : WAW'(1);
                r_cidx <= '0;
            end else if (i_cmd.scan_step) begin
                if (r_ridx != LAST_WORD) r_ridx <= r_ridx + WAW'(1);
                r_cidx <= r_cidx + WAW'(1);
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= pfba_pkg::t_mode'(i_mode);
            r_addr <= i_frame_address;
        end
        if (i_cmd.finish) begin
            r_res_address <= n_res_address;
            r_res_in_use  <= n_res_in_use;
            r_res_status  <= n_res_status;
        end
    end

    assign o_result_address = r_res_address;
    assign o_frame_in_use   = r_res_in_use;
    assign o_status         = r_res_status;

endmodule

/* sv/page_frame_bitmap_allocator_top.sv */
`timescale 1ns / 1ps
// Page frame bitmap allocator, first fit: top level with APB register and stream ports.
// Free/test/mark read the addressed bitmap word, then register the result; allocate scans
//   bitmap words (up to 128 at the default size, none when frame_count is zero), one word
//   per cycle from the simple dual-port bitmap memory read in the scan loop. The next item
//   is taken the cycle after the result registers.
// One item in flight; the next item is taken while a result waits in the output register.
// Reset (sync, active low): a clearing pass writes every bitmap word, one per cycle,
//   leaving only frame 0 used; no item is accepted meanwhile. frame_count resets to 4096.

module page_frame_bitmap_allocator_top #(
    parameter int MAX_FRAMES = 4096,
    parameter int PAGE_BYTES = 4096   // power of two
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration port
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [pfba_pkg::APB_AW-1:0]   i_paddr,
    input  logic [pfba_pkg::APB_DW-1:0]   i_pwdata,
    output logic [pfba_pkg::APB_DW-1:0]   o_prdata,
    output logic                          o_pready,
    // request stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [31:0]                   i_s_tdata,   // [31:0] frame_address
    input  logic [1:0]                    i_s_tuser,   // [1:0] mode
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [39:0]                   o_m_tdata,   // [31:0] result_address, [32] frame_in_use
    output logic [1:0]                    o_m_tuser    // [1:0] status
);

    logic [pfba_pkg::FC_W-1:0] r_frame_count;
    logic                      w_cfg_wr;
    logic                      w_sel_fc;
    pfba_pkg::t_cmd            w_cmd;
    pfba_pkg::t_stat           w_stat;
    logic [31:0]               w_result_address;
    logic                      w_frame_in_use;
    logic [1:0]                w_status;

    // one register at byte address 0; bit 2 picks the register slot
    assign w_sel_fc = (i_paddr[pfba_pkg::APB_AW-1:2] == 1'(pfba_pkg::REG_FRAME_CNT));
    assign w_cfg_wr = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready = 1'b1;
    assign o_prdata = w_sel_fc ? {{(pfba_pkg::APB_DW - pfba_pkg::FC_W){1'b0}}, r_frame_count}
                               : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= pfba_pkg::FC_RESET;
        end else if (w_cfg_wr && w_sel_fc) begin
            r_frame_count <= i_pwdata[pfba_pkg::FC_W-1:0];
        end
    end

    pfba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pfba_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_frame_count    (r_frame_count),
        .i_mode           (i_s_tuser),
        .i_frame_address  (i_s_tdata),
        .o_result_address (w_result_address),
        .o_frame_in_use   (w_frame_in_use),
        .o_status         (w_status)
    );

    assign o_m_tdata = {7'd0, w_frame_in_use, w_result_address};
    assign o_m_tuser = w_status;

endmodule

/* tb/tb_page_frame_bitmap_allocator_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for page_frame_bitmap_allocator_top (first-fit frame bitmap).
// Depends on pfba_pkg and the top level only; predicts every result and checks it in order.

module tb_page_frame_bitmap_allocator_top;

    localparam int unsigned MAX_FRAMES   = 4096;
    localparam int unsigned PAGE_BYTES   = 4096;
    localparam int unsigned BITMAP_WORDS = (MAX_FRAMES + 31) / 32;
    // Longest legal silence: the clearing pass after reset, a HOLD_CYCLES receiver
    // hold-off on top of a full allocate scan, and the sender's idle gaps. Taken
    // several times over.
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned END_SETTLE     = 200;   // > worst-case scan latency
    localparam int unsigned PHASE_ITEMS    = 160;

    // one result item as the block should present it
    typedef struct packed {
        logic [31:0]       address;
        logic              in_use;
        pfba_pkg::t_status status;
    } t_frame_result;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_psel     = 1'b0;
    logic                          i_penable  = 1'b0;
    logic                          i_pwrite   = 1'b0;
    logic [pfba_pkg::APB_AW-1:0]   i_paddr    = '0;
    logic [pfba_pkg::APB_DW-1:0]   i_pwdata   = '0;
    logic [pfba_pkg::APB_DW-1:0]   o_prdata;
    logic                          o_pready;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [31:0]                   i_s_tdata  = '0;   // [31:0] frame_address
    logic [1:0]                    i_s_tuser  = '0;   // [1:0] mode
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [39:0]                   o_m_tdata;         // [31:0] result_address, [32] frame_in_use
    logic [1:0]                    o_m_tuser;         // [1:0] status

    // predictor state: one used bit per frame, plus the frame_count register
    logic [31:0]                   frames_used [BITMAP_WORDS];
    logic [pfba_pkg::FC_W-1:0]     frame_count_reg;
    t_frame_result                 pending_results[$];

    // traffic shaping shared by the sender, the receiver and the tests
    bit                  idle_on      = 1'b0;
    int unsigned         hold_request = 0;
    int unsigned         hold_left    = 0;
    int unsigned         stall_left   = 0;
    int unsigned         quiet_cycles = 0;

    // bookkeeping
    int unsigned         mismatches     = 0;
    int unsigned         items_sent     = 0;
    int unsigned         results_seen   = 0;
    int unsigned         count_settings = 0;
    int unsigned         input_stalls   = 0;
    int unsigned         mode_seen [4];
    int unsigned         status_seen [3];

    page_frame_bitmap_allocator_top #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BYTES (PAGE_BYTES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int unsigned managed_frames();
        return (frame_count_reg > MAX_FRAMES) ? MAX_FRAMES : frame_count_reg;
    endfunction

    // Applies one request to the bitmap copy and returns the result it gives.
    function automatic t_frame_result serve_request(pfba_pkg::t_mode mode, logic [31:0] addr);
        t_frame_result r;
        int unsigned   limit;
        int unsigned   f;
        r.address = 32'd0;
        r.in_use  = 1'b0;
        r.status  = pfba_pkg::STAT_OK;
        limit     = managed_frames();
        if (mode == pfba_pkg::MODE_ALLOC) begin
            // first fit: lowest clear bit below the managed count
            r.status = pfba_pkg::STAT_NOFREE;
            for (int unsigned i = 0; i < limit; i++) begin
                if (!frames_used[i / 32][i % 32]) begin
                    frames_used[i / 32][i % 32] = 1'b1;
                    r.address = i * PAGE_BYTES;
                    r.status  = pfba_pkg::STAT_OK;
                    break;
                end
            end
        end else if (!(mode == pfba_pkg::MODE_FREE && addr == 32'd0)) begin
            // a free of exactly address zero is dropped; anything else is indexed
            f = addr / PAGE_BYTES;
            if (f >= limit) begin
                r.status = pfba_pkg::STAT_BEYOND;
            end else begin
                case (mode)
                    pfba_pkg::MODE_FREE: frames_used[f / 32][f % 32] = 1'b0;
                    pfba_pkg::MODE_TEST: r.in_use = frames_used[f / 32][f % 32];
                    default:             frames_used[f / 32][f % 32] = 1'b1;
                endcase
            end
        end
        return r;
    endfunction

    function automatic void reset_frame_model();
        foreach (frames_used[w]) frames_used[w] = 32'd0;
        frames_used[0]  = 32'd1;
        frame_count_reg = pfba_pkg::FC_RESET;
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready generator and in-order checker
    // ------------------------------------------------------------------

    // Random stall bursts when idling is on; a requested hold-off is counted here.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_request != 0) begin
            i_m_tready   <= 1'b0;
            hold_left    <= hold_request - 1;
            hold_request = 0;
        end else if (stall_left != 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 17);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 10) $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with none expected: tdata=%h tuser=%0d",
                                          o_m_tdata, o_m_tuser));
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[31:0] !== want.address)
                    report_mismatch($sformatf("result_address exp %h got %h",
                                              want.address, o_m_tdata[31:0]));
                if (o_m_tdata[32] !== want.in_use)
                    report_mismatch($sformatf("frame_in_use exp %0d got %0b",
                                              want.in_use, o_m_tdata[32]));
                if (o_m_tuser !== want.status)
                    report_mismatch($sformatf("status exp %0d got %0d",
                                              want.status, o_m_tuser));
                if (o_m_tdata[39:33] !== 7'd0)
                    report_mismatch($sformatf("tdata padding exp 0 got %h",
                                              o_m_tdata[39:33]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no handshake on any port
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_s_tvalid && !o_s_tready) input_stalls++;
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_psel && i_penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_results.size());
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one item, waits for the handshake, then records its expected result.
    // tvalid stays high on return so back-to-back items need no extra step.
    task automatic send_request(input pfba_pkg::t_mode mode, input logic [31:0] addr);
        t_frame_result want;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= addr;
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        want = serve_request(mode, addr);
        pending_results.push_back(want);
        items_sent++;
        mode_seen[mode]++;
        status_seen[want.status]++;
    endtask

    // Drops tvalid and waits until every expected result has been checked.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // APB write of frame_count followed by a read back. Block must be idle.
    task automatic write_frame_count(input logic [31:0] value);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= pfba_pkg::APB_AW'(pfba_pkg::REG_FRAME_CNT * 4);
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        frame_count_reg = value[pfba_pkg::FC_W-1:0];
        count_settings++;
        // read phase, psel held
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        if (o_prdata !== pfba_pkg::APB_DW'(frame_count_reg))
            report_mismatch($sformatf("frame_count read back exp %h got %h",
                                      pfba_pkg::APB_DW'(frame_count_reg), o_prdata));
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    // Mostly in-range addresses with random page offsets, a few at the count
    // boundary, exact zero, and fully random words.
    function automatic logic [31:0] pick_frame_address();
        int unsigned limit;
        int unsigned f;
        limit = managed_frames();
        case ($urandom_range(0, 19))
            0:       return $urandom();
            1:       return 32'd0;
            2:       f = limit + $urandom_range(0, 2);
            default: f = (limit == 0) ? 0 : $urandom_range(0, limit - 1);
        endcase
        return {f[19:0], 12'($urandom())};
    endfunction

    task automatic send_random_request(input int unsigned alloc_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct)
            send_request(pfba_pkg::MODE_ALLOC, $urandom());   // address field is don't-care here
        else if (roll < alloc_pct + (100 - alloc_pct) / 2)
            send_request(pfba_pkg::MODE_FREE, pick_frame_address());
        else if (roll < 97)
            send_request(($urandom_range(0, 1) == 0) ? pfba_pkg::MODE_TEST : pfba_pkg::MODE_MARK,
                         pick_frame_address());
        else
            send_request(pfba_pkg::t_mode'($urandom_range(0, 3)), $urandom());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Frame 0 comes out of reset marked used; a free of address zero is a no-op.
    task automatic test_reset_state();
        send_request(pfba_pkg::MODE_TEST, 32'h0000_0000);
        send_request(pfba_pkg::MODE_FREE, 32'h0000_0000);
        send_request(pfba_pkg::MODE_TEST, 32'h0000_0FFF);
    endtask

    // Every mode, first-fit order, reuse after free, and a nonzero address
    // inside frame 0 actually freeing it.
    task automatic test_each_mode();
        send_request(pfba_pkg::MODE_ALLOC, 32'hFFFF_FFFF);
        send_request(pfba_pkg::MODE_ALLOC, 32'h0000_0000);
        send_request(pfba_pkg::MODE_MARK,  32'h0000_3000);
        send_request(pfba_pkg::MODE_ALLOC, 32'h1234_5678);
        send_request(pfba_pkg::MODE_FREE,  32'h0000_1ABC);
        send_request(pfba_pkg::MODE_TEST,  32'h0000_1000);
        send_request(pfba_pkg::MODE_ALLOC, 32'h0000_0000);
        send_request(pfba_pkg::MODE_FREE,  32'h0000_0001);
        send_request(pfba_pkg::MODE_ALLOC, 32'h0000_0000);   // hands back frame 0, address 0
    endtask

    // Last managed frame and the first frame past it, plus the all-ones address.
    task automatic test_address_range();
        send_request(pfba_pkg::MODE_TEST, 32'h00FF_F000);
        send_request(pfba_pkg::MODE_MARK, 32'h00FF_FFFF);
        send_request(pfba_pkg::MODE_TEST, 32'hFFFF_FFFF);
        send_request(pfba_pkg::MODE_FREE, 32'h0100_0000);
        send_request(pfba_pkg::MODE_MARK, 32'hFFFF_FFFF);
    endtask

    // Count of zero, a count past MAX_FRAMES, and a tiny store run to full.
    task automatic test_frame_count_extremes();
        drain_results();
        write_frame_count(32'd0);
        send_request(pfba_pkg::MODE_ALLOC, 32'h0000_0000);
        send_request(pfba_pkg::MODE_TEST,  32'h0000_0000);
        send_request(pfba_pkg::MODE_FREE,  32'h0000_0000);
        send_request(pfba_pkg::MODE_MARK,  32'h0000_1000);
        drain_results();
        write_frame_count(32'h0000_1FFF);          // saturates to MAX_FRAMES
        send_request(pfba_pkg::MODE_TEST,  32'h00FF_F000);
        send_request(pfba_pkg::MODE_TEST,  32'h0100_0000);
        drain_results();
        write_frame_count(32'd3);
        send_request(pfba_pkg::MODE_ALLOC, 32'h0000_0000);   // frames 0..2 all taken
        send_request(pfba_pkg::MODE_FREE,  32'h0000_2000);
        send_request(pfba_pkg::MODE_ALLOC, 32'h0000_0000);
        send_request(pfba_pkg::MODE_ALLOC, 32'h0000_0000);
        drain_results();
    endtask

    // Receiver holds off long enough that the block backs up and stalls its
    // input while the sender keeps offering; the sender then waits for all.
    task automatic test_backpressure();
        write_frame_count(32'd4096);
        idle_on      = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (12) send_random_request(50);
        drain_results();
    endtask

    // Phases of random traffic, each under its own frame count. The bitmap is
    // kept across phases, so lowered counts hide bits that later reappear.
    task automatic test_random_traffic();
        int unsigned counts [10] = '{4096, 40, 1, 300, 8191, 0, 33, 4096, 96, 64};
        int unsigned pct;
        idle_on = 1'b1;
        for (int p = 0; p < 10; p++) begin
            write_frame_count(($urandom() & 32'hFFFF_E000) | counts[p]);
            pct = (p % 3 == 0) ? 70 : 45;
            repeat (PHASE_ITEMS) send_random_request(pct);
            drain_results();
        end
        // closing stretch at full rate, no idling on either side
        idle_on = 1'b0;
        write_frame_count($urandom_range(1, 4096));
        repeat (200) send_random_request(55);
    endtask

    initial begin
        reset_frame_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_each_mode();
        test_address_range();
        test_frame_count_extremes();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (END_SETTLE) @(posedge i_clk);
        $display("Run: %0d requests (alloc %0d, free %0d, test %0d, mark %0d) under %0d counts",
                 items_sent, mode_seen[pfba_pkg::MODE_ALLOC], mode_seen[pfba_pkg::MODE_FREE],
                 mode_seen[pfba_pkg::MODE_TEST], mode_seen[pfba_pkg::MODE_MARK],
                 count_settings);
        $display("Results: %0d checked, %0d ok, %0d full, %0d beyond; %0d stalled cycles, %0d bad",
                 results_seen, status_seen[pfba_pkg::STAT_OK],
                 status_seen[pfba_pkg::STAT_NOFREE], status_seen[pfba_pkg::STAT_BEYOND],
                 input_stalls, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
